// File: src/stsad_pkg.sv
// ----------------------------------------------------------------------------
// stsad_pkg: shared constants, types and helpers
// Sizes of the pixel stores, window, search range and divider.
// ----------------------------------------------------------------------------
`default_nettype none
package stsad_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int WINDOW_HALF = 5;
  localparam int MAX_SEARCH  = 64;

  localparam int WIN_SIZE  = 2 * WINDOW_HALF + 1;
  localparam int WIN_CW    = $clog2(WIN_SIZE);
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int PIX_AW    = XW + YW;
  localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int DW        = $clog2(MAX_SEARCH);
  localparam int COST_W    = 26;
  localparam int SUM_W     = 17;
  localparam int CNT_W     = 7;

  // Divider sizes cover the refinement quotient, the larger of the two uses.
  localparam int DIV_N  = 36;
  localparam int DIV_D  = 31;
  localparam int DIV_CW = $clog2(DIV_N + 1);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SEARCH = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_D-1:0] divisor;
  } div_req_t;

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    absdiff8 = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [9:0] pair_diff(input logic [23:0] lw, input logic [23:0] rw);
    pair_diff = {2'b00, absdiff8(lw[23:16], rw[23:16])}
              + {2'b00, absdiff8(lw[15:8], rw[15:8])}
              + {2'b00, absdiff8(lw[7:0], rw[7:0])};
  endfunction

endpackage
`default_nettype wire

// File: src/stsad_ram.sv
// ----------------------------------------------------------------------------
// stsad_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module stsad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/stsad_div.sv
// ----------------------------------------------------------------------------
// stsad_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stsad_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire stsad_pkg::div_req_t      req,
  output logic                          done,
  output logic [stsad_pkg::DIV_N-1:0]   quotient
);
  import stsad_pkg::*;

  logic [DIV_N-1:0]  quo_r, quo_nxt;
  logic [DIV_D-1:0]  rem_r, rem_nxt;
  logic [DIV_D-1:0]  dvs_r, dvs_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DIV_D:0]    trial;

  assign trial = {rem_r, quo_r[DIV_N-1]};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_D'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_N-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_D-1:0];
        quo_nxt = {quo_r[DIV_N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_N - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: src/stereo_sad_disparity.sv
// ----------------------------------------------------------------------------
// stereo_sad_disparity: stereo block matching with sub-pixel refinement
// Mean absolute RGB difference over an 11x11 window, parabola refinement.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. A load command
// (in_cmd = 0) writes the left and right pixel at (in_col, in_row) into the
// two pixel memories in the transfer cycle; it leaves busy low and gives no
// result. A query command (in_cmd = 1) searches disparities from zero upward
// and returns one result, marked by a single-cycle out_valid strobe.
// Each candidate disparity walks the 121 window positions, one left/right
// pixel pair per cycle from the two pixel memories, then passes a drain
// state, a check state and, if any pair was inside the image, a divide for
// the mean (36 quotient steps), and a step to the next candidate. The
// refinement decision and, where it applies, its own divide follow the last
// candidate. The window walk and the shared divider take most of the time.
// The receiver of results cannot stall; the result stands for one cycle.
// Reset restores the registers to 384 x 288 with search length 20 and
// returns the control to idle. The pixel memories are not cleared; a query
// must only touch pixels that were loaded. The per-query cost memory is
// tracked by the last disparity written, so it needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module stereo_sad_disparity (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [8:0]  in_col,
  input  wire logic [8:0]  in_row,
  input  wire logic [7:0]  in_left_red,
  input  wire logic [7:0]  in_left_green,
  input  wire logic [7:0]  in_left_blue,
  input  wire logic [7:0]  in_right_red,
  input  wire logic [7:0]  in_right_green,
  input  wire logic [7:0]  in_right_blue,
  // Result channel
  output logic             out_valid,
  output logic [15:0]      out_disparity_fixed,
  output logic             out_refined,
  output logic [25:0]      out_best_cost,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import stsad_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WIN   = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_DIVW  = 4'd4;
  localparam logic [3:0] S_NEXT  = 4'd5;
  localparam logic [3:0] S_REF0  = 4'd6;
  localparam logic [3:0] S_REF1  = 4'd7;
  localparam logic [3:0] S_REF2  = 4'd8;
  localparam logic [3:0] S_REF3  = 4'd9;
  localparam logic [3:0] S_RDIV  = 4'd10;

  localparam logic       CMD_LOAD = 1'b0;

  // Configuration registers.
  logic [9:0] width_reg_r, height_reg_r;
  logic [5:0] search_reg_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_reg_r  <= 10'd384;
      height_reg_r <= 10'd288;
      search_reg_r <= 6'd20;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_reg_r  <= pwdata[9:0];
        REG_HEIGHT: height_reg_r <= pwdata[9:0];
        REG_SEARCH: search_reg_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {22'd0, width_reg_r};
      REG_HEIGHT: prdata = {22'd0, height_reg_r};
      REG_SEARCH: prdata = {26'd0, search_reg_r};
      default:    prdata = '0;
    endcase
  end

  // Control and datapath registers.
  logic [3:0]        state_r, state_nxt;
  logic [8:0]        col_r, col_nxt, row_r, row_nxt;
  logic [9:0]        w_r, w_nxt, h_r, h_nxt;
  logic [DW-1:0]     smax_r, smax_nxt, d_r, d_nxt, last_d_r, last_d_nxt;
  logic [WIN_CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic              vld_d1_r, vld_d1_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              have_r, have_nxt;
  logic [DW-1:0]     best_d_r, best_d_nxt;
  logic [COST_W-1:0] best_cost_r, best_cost_nxt;
  logic [COST_W-1:0] c1_r, c1_nxt;
  logic signed [29:0] den_r, den_nxt;
  logic signed [34:0] num_r, num_nxt;
  logic              neg_r, neg_nxt;
  logic              ov_r, ov_nxt;
  logic [15:0]       od_r, od_nxt;
  logic              oref_r, oref_nxt;
  logic [COST_W-1:0] ocost_r, ocost_nxt;

  // Window position arithmetic.
  logic signed [11:0] x1, x2, yy;
  logic               pix_ok;

  assign x1 = $signed({3'b000, col_r}) + $signed({{(12-WIN_CW){1'b0}}, i_r})
              - 12'(WINDOW_HALF);
  assign x2 = x1 - $signed({{(12-DW){1'b0}}, d_r});
  assign yy = $signed({3'b000, row_r}) + $signed({{(12-WIN_CW){1'b0}}, j_r})
              - 12'(WINDOW_HALF);
  assign pix_ok = (x1 >= 0) && (x2 >= 0) && (x1 < $signed({2'b00, w_r}))
                  && (yy >= 0) && (yy < $signed({2'b00, h_r}));

  // Pixel memories: the write port serves loads, the read port the window.
  logic              pix_we;
  logic [PIX_AW-1:0] pix_waddr, l_raddr, r_raddr;
  logic [23:0]       l_rdata, r_rdata;

  assign pix_we    = start && !busy && (in_cmd == CMD_LOAD);
  assign pix_waddr = {in_row[YW-1:0], in_col[XW-1:0]};
  assign l_raddr   = {yy[YW-1:0], x1[XW-1:0]};
  assign r_raddr   = {yy[YW-1:0], x2[XW-1:0]};

  stsad_ram #(.WIDTH(24), .DEPTH(PIX_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata ({in_left_red, in_left_green, in_left_blue}),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  stsad_ram #(.WIDTH(24), .DEPTH(PIX_DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata ({in_right_red, in_right_green, in_right_blue}),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // Cost memory: written once per candidate, read back for refinement.
  logic              cost_we;
  logic [COST_W-1:0] cost_wdata, cost_rdata;
  logic [DW-1:0]     cost_raddr;

  stsad_ram #(.WIDTH(COST_W), .DEPTH(MAX_SEARCH)) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .waddr (d_r),
    .wdata (cost_wdata),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  // Shared divider for the window mean and the refinement step.
  div_req_t         div_req;
  logic             div_done;
  logic [DIV_N-1:0] div_q;

  stsad_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Helper values for the state machine.
  logic [DW:0]        d_inc;
  logic               more_d;
  logic [COST_W-1:0]  c3;
  logic signed [28:0] curv;
  logic signed [26:0] slope;
  logic [34:0]        an;
  logic [29:0]        ad;
  logic signed [39:0] qs, res;
  logic [15:0]        res_sat;
  logic [COST_W-1:0]  mean;

  assign d_inc  = {1'b0, d_r} + 1'b1;
  assign more_d = (d_inc <= {1'b0, smax_r}) && ({3'b000, d_inc} < ({1'b0, col_r} + 10'(WINDOW_HALF)));
  assign c3     = ({1'b0, best_d_r} + 1'b1 <= {1'b0, last_d_r}) ? cost_rdata : '0;
  assign curv   = $signed({3'b000, c1_r}) + $signed({3'b000, c3})
                  - $signed({2'b00, best_cost_r, 1'b0});
  assign slope  = $signed({1'b0, c3}) - $signed({1'b0, c1_r});
  assign an     = num_r[34] ? 35'(-num_r) : num_r;
  assign ad     = den_r[29] ? 30'(-den_r) : den_r;
  assign qs     = neg_r ? -$signed({4'b0000, div_q}) : $signed({4'b0000, div_q});
  assign res    = $signed({{(32-DW){1'b0}}, best_d_r, 8'd0}) - qs;
  assign res_sat = (res > 40'sd32767) ? 16'h7FFF :
                   (res < -40'sd32768) ? 16'h8000 : res[15:0];
  assign mean   = div_q[COST_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    smax_nxt      = smax_r;
    d_nxt         = d_r;
    last_d_nxt    = last_d_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    vld_d1_nxt    = 1'b0;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    have_nxt      = have_r;
    best_d_nxt    = best_d_r;
    best_cost_nxt = best_cost_r;
    c1_nxt        = c1_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    neg_nxt       = neg_r;
    ov_nxt        = 1'b0;
    od_nxt        = od_r;
    oref_nxt      = oref_r;
    ocost_nxt     = ocost_r;
    cost_we       = 1'b0;
    cost_wdata    = '0;
    cost_raddr    = best_d_r;
    div_req       = '0;

    // The pair read in the previous cycle is accumulated here.
    if (vld_d1_r) begin
      sum_nxt = sum_r + SUM_W'(pair_diff(l_rdata, r_rdata));
      cnt_nxt = cnt_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start && in_cmd != CMD_LOAD) begin
          col_nxt       = in_col;
          row_nxt       = in_row;
          w_nxt         = (width_reg_r > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : width_reg_r;
          h_nxt         = (height_reg_r > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : height_reg_r;
          smax_nxt      = (search_reg_r > 6'(MAX_SEARCH - 1)) ? 6'(MAX_SEARCH - 1)
                                                               : search_reg_r;
          d_nxt         = '0;
          i_nxt         = '0;
          j_nxt         = '0;
          sum_nxt       = '0;
          cnt_nxt       = '0;
          have_nxt      = 1'b0;
          best_d_nxt    = '0;
          best_cost_nxt = '0;
          state_nxt     = S_WIN;
        end
      end
      S_WIN: begin
        vld_d1_nxt = pix_ok;
        if (j_r == WIN_CW'(WIN_SIZE - 1)) begin
          j_nxt = '0;
          if (i_r == WIN_CW'(WIN_SIZE - 1)) begin
            state_nxt = S_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cnt_r == '0) begin
          cost_we   = 1'b1;
          state_nxt = S_NEXT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_N'({sum_r, 16'd0});
          div_req.divisor  = DIV_D'(cnt_r);
          state_nxt        = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          cost_we    = 1'b1;
          cost_wdata = mean;
          if (!have_r || mean < best_cost_r) begin
            have_nxt      = 1'b1;
            best_cost_nxt = mean;
            best_d_nxt    = d_r;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        last_d_nxt = d_r;
        if (more_d) begin
          d_nxt     = d_inc[DW-1:0];
          i_nxt     = '0;
          j_nxt     = '0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_WIN;
        end else begin
          state_nxt = S_REF0;
        end
      end
      S_REF0: begin
        if (have_r && best_d_r != '0 && best_d_r < smax_r) begin
          cost_raddr = best_d_r - 1'b1;
          state_nxt  = S_REF1;
        end else begin
          ov_nxt    = 1'b1;
          od_nxt    = 16'({best_d_r, 8'd0});
          oref_nxt  = 1'b0;
          ocost_nxt = best_cost_r;
          state_nxt = S_IDLE;
        end
      end
      S_REF1: begin
        c1_nxt     = cost_rdata;
        cost_raddr = best_d_r + 1'b1;
        state_nxt  = S_REF2;
      end
      S_REF2: begin
        den_nxt   = {curv, 1'b0};
        num_nxt   = {slope, 8'd0};
        state_nxt = S_REF3;
      end
      S_REF3: begin
        if (den_r == '0) begin
          ov_nxt    = 1'b1;
          od_nxt    = 16'({best_d_r, 8'd0});
          oref_nxt  = 1'b0;
          ocost_nxt = best_cost_r;
          state_nxt = S_IDLE;
        end else begin
          neg_nxt          = num_r[34] ^ den_r[29];
          div_req.start    = 1'b1;
          div_req.dividend = DIV_N'({an, 1'b0}) + DIV_N'(ad);
          div_req.divisor  = {ad, 1'b0};
          state_nxt        = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_sat;
          oref_nxt  = 1'b1;
          ocost_nxt = best_cost_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vld_d1_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vld_d1_r <= vld_d1_nxt;
      ov_r     <= ov_nxt;
    end
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    smax_r      <= smax_nxt;
    d_r         <= d_nxt;
    last_d_r    <= last_d_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    sum_r       <= sum_nxt;
    cnt_r       <= cnt_nxt;
    have_r      <= have_nxt;
    best_d_r    <= best_d_nxt;
    best_cost_r <= best_cost_nxt;
    c1_r        <= c1_nxt;
    den_r       <= den_nxt;
    num_r       <= num_nxt;
    neg_r       <= neg_nxt;
    od_r        <= od_nxt;
    oref_r      <= oref_nxt;
    ocost_r     <= ocost_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = ov_r;
  assign out_disparity_fixed = od_r;
  assign out_refined         = oref_r;
  assign out_best_cost       = ocost_r;

  // A result is only ever presented once the search has returned to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a query is still running");

  // A load transfer never yields a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |=> !out_valid)
    else $error("result after a load command");

  // The window counters stay inside the window during the walk.
  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WIN) |-> (i_r < WIN_CW'(WIN_SIZE) && j_r < WIN_CW'(WIN_SIZE)))
    else $error("window counter out of range");

endmodule
`default_nettype wire

// File: verif/stereo_sad_checker.sv
// ----------------------------------------------------------------------------
// stereo_sad_checker: disparity predictor and result scoreboard
// Watches the command, result and register channels of the stereo matcher,
// keeps its own pixel images and settings, and compares every result.
// ----------------------------------------------------------------------------
module stereo_sad_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_cmd,
  input  logic [8:0]  in_col,
  input  logic [8:0]  in_row,
  input  logic [7:0]  in_left_red,
  input  logic [7:0]  in_left_green,
  input  logic [7:0]  in_left_blue,
  input  logic [7:0]  in_right_red,
  input  logic [7:0]  in_right_green,
  input  logic [7:0]  in_right_blue,
  input  logic        out_valid,
  input  logic [15:0] out_disparity_fixed,
  input  logic        out_refined,
  input  logic [25:0] out_best_cost,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import stsad_pkg::*;

  typedef struct {
    logic [15:0] disparity;
    logic        refined;
    logic [25:0] cost;
  } match_t;

  logic [23:0] left_img [int];
  logic [23:0] right_img [int];
  match_t      pending_matches [$];
  logic [9:0]  img_w;
  logic [9:0]  img_h;
  logic [5:0]  img_s;

  function automatic logic [23:0] pixel_at(input bit is_left, input int addr);
    if (is_left) return left_img.exists(addr) ? left_img[addr] : 24'd0;
    return right_img.exists(addr) ? right_img[addr] : 24'd0;
  endfunction

  function automatic int chan_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // Block matching search for one query position, with parabolic refinement.
  function automatic match_t match_disparity(input int c, input int r);
    match_t      m;
    longint      costs [MAX_SEARCH];
    longint      sum, cnt, best, c1, c2, c3, den, num, an, ad, q, disp;
    int          w, h, smax, best_d, x1, x2, y;
    bit          found;
    logic [23:0] lw, rw;
    w = (img_w < MAX_WIDTH) ? int'(img_w) : MAX_WIDTH;
    h = (img_h < MAX_HEIGHT) ? int'(img_h) : MAX_HEIGHT;
    smax = (img_s < MAX_SEARCH - 1) ? int'(img_s) : MAX_SEARCH - 1;
    foreach (costs[k]) costs[k] = 0;
    found = 0;
    best = 0;
    best_d = 0;
    for (int d = 0; d <= smax && c - d + WINDOW_HALF > 0; d++) begin
      sum = 0;
      cnt = 0;
      for (int i = -WINDOW_HALF; i <= WINDOW_HALF; i++) begin
        x1 = c + i;
        x2 = c + i - d;
        if (x1 < 0 || x2 < 0 || x1 >= w || x2 >= w) continue;
        for (int j = -WINDOW_HALF; j <= WINDOW_HALF; j++) begin
          y = r + j;
          if (y < 0 || y >= h) continue;
          lw = pixel_at(1, y * MAX_WIDTH + x1);
          rw = pixel_at(0, y * MAX_WIDTH + x2);
          sum += chan_diff(lw[23:16], rw[23:16]) + chan_diff(lw[15:8], rw[15:8])
               + chan_diff(lw[7:0], rw[7:0]);
          cnt++;
        end
      end
      // An empty window keeps a zero cost and can never win.
      if (cnt != 0) begin
        costs[d] = (sum << 16) / cnt;
        if (!found || costs[d] < best) begin
          found = 1;
          best = costs[d];
          best_d = d;
        end
      end
    end
    disp = longint'(best_d) * 256;
    m.refined = 0;
    if (found && best_d > 0 && best_d < smax) begin
      c1 = costs[best_d - 1];
      c2 = costs[best_d];
      c3 = costs[best_d + 1];
      den = 2 * (c1 - 2 * c2 + c3);
      if (den != 0) begin
        num = (c3 - c1) * 256;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        if ((num < 0) != (den < 0)) q = -q;
        disp -= q;
        m.refined = 1;
      end
    end
    if (disp > 32767) disp = 32767;
    if (disp < -32768) disp = -32768;
    m.disparity = disp[15:0];
    m.cost = best[25:0];
    return m;
  endfunction

  always @(posedge clk) begin
    match_t exp_m;
    int     addr;
    if (!rst_n) begin
      img_w <= 10'd384;
      img_h <= 10'd288;
      img_s <= 6'd20;
      pending_matches.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIDTH:  img_w <= pwdata[9:0];
          REG_HEIGHT: img_h <= pwdata[9:0];
          REG_SEARCH: img_s <= pwdata[5:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_cmd) begin
          pending_matches.push_back(match_disparity(in_col, in_row));
        end else begin
          addr = int'(in_row) * MAX_WIDTH + int'(in_col);
          left_img[addr] = {in_left_red, in_left_green, in_left_blue};
          right_img[addr] = {in_right_red, in_right_green, in_right_blue};
        end
      end
      if (out_valid) begin
        if (pending_matches.size() == 0) begin
          $display("%0t: result with no query waiting: disp %0d cost %0d", $realtime,
                   $signed(out_disparity_fixed), out_best_cost);
          errors <= errors + 1;
        end else begin
          exp_m = pending_matches.pop_front();
          if (exp_m.disparity !== out_disparity_fixed || exp_m.refined !== out_refined ||
              exp_m.cost !== out_best_cost) begin
            $display({"%0t: mismatch: expected disp %0d refined %0b cost %0d,",
                      " got disp %0d refined %0b cost %0d"},
                     $realtime, $signed(exp_m.disparity), exp_m.refined, exp_m.cost,
                     $signed(out_disparity_fixed), out_refined, out_best_cost);
            errors <= errors + 1;
          end
        end
      end
      outstanding <= pending_matches.size();
    end
  end

endmodule

// File: verif/stereo_sad_disparity_tb.sv
// ----------------------------------------------------------------------------
// stereo_sad_disparity_tb: regression for the stereo disparity matcher
// Loads a small image patch, then issues directed and random loads and
// queries under several image and search settings, with random gaps.
// ----------------------------------------------------------------------------
module stereo_sad_disparity_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stsad_pkg::*;

  // Every pixel of this patch is loaded before the first query, so queries
  // are only issued where their windows stay inside it or outside the image.
  localparam int PATCH_W = 16;
  localparam int PATCH_H = 11;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [8:0]  in_col;
  logic [8:0]  in_row;
  logic [7:0]  in_left_red, in_left_green, in_left_blue;
  logic [7:0]  in_right_red, in_right_green, in_right_blue;
  logic        out_valid;
  logic [15:0] out_disparity_fixed;
  logic        out_refined;
  logic [25:0] out_best_cost;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors;
  int          outstanding;

  // Effective settings, tracked here only to keep queries on loaded pixels.
  int          eff_w, eff_h, eff_s;
  bit          gaps_on;

  stereo_sad_disparity DUT (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_col, .in_row,
    .in_left_red, .in_left_green, .in_left_blue,
    .in_right_red, .in_right_green, .in_right_blue,
    .out_valid, .out_disparity_fixed, .out_refined, .out_best_cost,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  stereo_sad_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_col, .in_row,
    .in_left_red, .in_left_green, .in_left_blue,
    .in_right_red, .in_right_green, .in_right_blue,
    .out_valid, .out_disparity_fixed, .out_refined, .out_best_cost,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

  // One register write: a setup phase, then an access phase.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Settings change only once the block is idle and every result is back.
  // Loads leave no result behind, so a short pause follows as well.
  task automatic set_image(input int w, input int h, input int s);
    start = 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_SEARCH, s);
    eff_w = (w < MAX_WIDTH) ? w : MAX_WIDTH;
    eff_h = (h < MAX_HEIGHT) ? h : MAX_HEIGHT;
    eff_s = (s < MAX_SEARCH - 1) ? s : MAX_SEARCH - 1;
  endtask

  // Drives one command and returns once its transfer has happened. The
  // command is held from one falling edge until busy is seen low.
  task automatic issue(input logic cmd, input int c, input int r,
                       input logic [47:0] rgb_pair);
    start = 1'b1;
    in_cmd = cmd;
    in_col = c[8:0];
    in_row = r[8:0];
    {in_left_red, in_left_green, in_left_blue,
     in_right_red, in_right_green, in_right_blue} = rgb_pair;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 28) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic logic [47:0] random_pair();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {24'hFFFFFF, 24'h000000};
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // True when every in-image pixel a query could read lies in the patch.
  function automatic bit query_safe(input int c, input int r);
    for (int x = c - WINDOW_HALF - eff_s; x <= c + WINDOW_HALF; x++)
      for (int y = r - WINDOW_HALF; y <= r + WINDOW_HALF; y++)
        if (x >= 0 && x < eff_w && y >= 0 && y < eff_h &&
            (x >= PATCH_W || y >= PATCH_H))
          return 0;
    return 1;
  endfunction

  task automatic random_query();
    int c, r;
    c = ($urandom_range(99) < 85) ? $urandom_range(0, 20) : $urandom_range(0, 511);
    r = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(0, 511);
    for (int tries = 0; tries < 20 && !query_safe(c, r); tries++) begin
      c = $urandom_range(0, 10);
      r = $urandom_range(0, 5);
    end
    // The patch corner is always covered, whatever the settings.
    if (!query_safe(c, r)) begin
      c = 0;
      r = 0;
    end
    issue(1'b1, c, r, 48'({$urandom, $urandom}));
  endtask

  task automatic random_phase(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 40)
        random_query();
      else if ($urandom_range(99) < 85)
        issue(1'b0, $urandom_range(0, PATCH_W - 1), $urandom_range(0, PATCH_H - 1),
              random_pair());
      else
        issue(1'b0, $urandom_range(0, 511), $urandom_range(0, 511), random_pair());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = 1'b0;
    in_col = '0;
    in_row = '0;
    {in_left_red, in_left_green, in_left_blue} = '0;
    {in_right_red, in_right_green, in_right_blue} = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b0;
    eff_w = 384;
    eff_h = 288;
    eff_s = 20;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Textured patch for everything that follows, loaded back to back.
    for (int y = 0; y < PATCH_H; y++)
      for (int x = 0; x < PATCH_W; x++)
        issue(1'b0, x, y, random_pair());

    // Directed queries at the reset settings: the left edge, where the
    // search range is cut short, a point inside the patch, and the far corner,
    // where every window is empty and there is no winner.
    issue(1'b1, 0, 0, '0);
    issue(1'b1, 10, 5, '0);
    issue(1'b1, 511, 511, '0);

    // The smallest image and no search at all.
    set_image(1, 1, 0);
    issue(1'b1, 0, 0, '0);
    issue(1'b1, 5, 5, '0);
    issue(1'b1, 6, 0, '0);

    // Full patch as the image, widest search, and an unknown register.
    set_image(PATCH_W, PATCH_H, 63);
    write_reg(2'd3, 32'hFFFF_FFFF);
    issue(1'b1, 15, 10, '0);
    issue(1'b1, 8, 5, '0);
    issue(1'b1, 300, 2, '0);
    gaps_on = 1'b1;
    random_phase(8);

    // Register values past the store size are clamped to it.
    set_image(1023, 1023, 63);
    issue(1'b1, 10, 5, '0);
    random_phase(8);

    set_image(12, 6, 5);
    random_phase(8);

    // A stretch with commands back to back.
    gaps_on = 1'b0;
    set_image(PATCH_W, 8, 1);
    random_phase(10);

    gaps_on = 1'b1;
    set_image(512, 512, 20);
    random_phase(10);

    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: stereo_sad_disparity.f
src/stsad_pkg.sv
src/stsad_ram.sv
src/stsad_div.sv
src/stereo_sad_disparity.sv
verif/stereo_sad_checker.sv
verif/stereo_sad_disparity_tb.sv
